// ===== sv/tkse_pkg.sv =====
// tkse_pkg: shared types and constants of the terminal key sequence encoder
// no dependencies; imported by every module of the block except tkse_checker
package tkse_pkg;

   localparam int KEYSYM_WIDTH = 29;
   localparam int TEXT_WIDTH   = 32;
   localparam int TLEN_WIDTH   = 3;
   localparam int MAX_BYTES    = 7;
   localparam int LEN_WIDTH    = 3;
   localparam int CSR_IDX_WIDTH = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CURSOR_SS3   = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KEYPAD_SS3   = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KEYMAP_READY = 2'd2;

   // bytes
   localparam logic [7:0] CH_ESC       = 8'h1B;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_O         = 8'h4F;
   localparam logic [7:0] CH_ONE       = 8'h31;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_TILDE     = 8'h7E;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_DEL       = 8'h7F;
   localparam logic [7:0] CH_PRINT_MIN = 8'h20;
   localparam logic [7:0] CH_NON_ASCII = 8'h80;
   localparam logic [7:0] CH_FS        = 8'h1C;
   localparam logic [7:0] CH_GS        = 8'h1D;
   localparam logic [7:0] CH_RS        = 8'h1E;
   localparam logic [7:0] CH_US        = 8'h1F;
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] FIN_A        = 8'h41;
   localparam logic [7:0] FIN_B        = 8'h42;
   localparam logic [7:0] FIN_C        = 8'h43;
   localparam logic [7:0] FIN_D        = 8'h44;
   localparam logic [7:0] FIN_F        = 8'h46;
   localparam logic [7:0] FIN_H        = 8'h48;
   localparam logic [7:0] FIN_P        = 8'h50;
   localparam logic [7:0] FIN_Q        = 8'h51;
   localparam logic [7:0] FIN_R        = 8'h52;
   localparam logic [7:0] FIN_S        = 8'h53;
   localparam logic [7:0] FIN_Z        = 8'h5A;
   localparam logic [7:0] KP_FIN_ENTER = 8'h4D;
   localparam logic [7:0] KP_FIN_MULT  = 8'h6A;
   localparam logic [7:0] KP_FIN_ADD   = 8'h6B;
   localparam logic [7:0] KP_FIN_SEP   = 8'h6C;
   localparam logic [7:0] KP_FIN_SUB   = 8'h6D;
   localparam logic [7:0] KP_FIN_DEC   = 8'h6E;
   localparam logic [7:0] KP_FIN_DIV   = 8'h6F;
   localparam logic [7:0] KP_FIN_DIGIT = 8'h70;

   // keysyms
   localparam logic [KEYSYM_WIDTH-1:0] KS_BACKSPACE = 29'hFF08;
   localparam logic [KEYSYM_WIDTH-1:0] KS_TAB       = 29'hFF09;
   localparam logic [KEYSYM_WIDTH-1:0] KS_RETURN    = 29'hFF0D;
   localparam logic [KEYSYM_WIDTH-1:0] KS_ESCAPE    = 29'hFF1B;
   localparam logic [KEYSYM_WIDTH-1:0] KS_HOME      = 29'hFF50;
   localparam logic [KEYSYM_WIDTH-1:0] KS_LEFT      = 29'hFF51;
   localparam logic [KEYSYM_WIDTH-1:0] KS_UP        = 29'hFF52;
   localparam logic [KEYSYM_WIDTH-1:0] KS_RIGHT     = 29'hFF53;
   localparam logic [KEYSYM_WIDTH-1:0] KS_DOWN      = 29'hFF54;
   localparam logic [KEYSYM_WIDTH-1:0] KS_PRIOR     = 29'hFF55;
   localparam logic [KEYSYM_WIDTH-1:0] KS_NEXT      = 29'hFF56;
   localparam logic [KEYSYM_WIDTH-1:0] KS_END       = 29'hFF57;
   localparam logic [KEYSYM_WIDTH-1:0] KS_INSERT    = 29'hFF63;
   localparam logic [KEYSYM_WIDTH-1:0] KS_KP_ENTER  = 29'hFF8D;
   localparam logic [KEYSYM_WIDTH-1:0] KS_KP_MULT   = 29'hFFAA;
   localparam logic [KEYSYM_WIDTH-1:0] KS_KP_ADD    = 29'hFFAB;
   localparam logic [KEYSYM_WIDTH-1:0] KS_KP_SEP    = 29'hFFAC;
   localparam logic [KEYSYM_WIDTH-1:0] KS_KP_SUB    = 29'hFFAD;
   localparam logic [KEYSYM_WIDTH-1:0] KS_KP_DEC    = 29'hFFAE;
   localparam logic [KEYSYM_WIDTH-1:0] KS_KP_DIV    = 29'hFFAF;
   localparam logic [KEYSYM_WIDTH-1:0] KS_KP_0      = 29'hFFB0;
   localparam logic [KEYSYM_WIDTH-1:0] KS_KP_9      = 29'hFFB9;
   localparam logic [KEYSYM_WIDTH-1:0] KS_F1        = 29'hFFBE;
   localparam logic [KEYSYM_WIDTH-1:0] KS_F2        = 29'hFFBF;
   localparam logic [KEYSYM_WIDTH-1:0] KS_F3        = 29'hFFC0;
   localparam logic [KEYSYM_WIDTH-1:0] KS_F4        = 29'hFFC1;
   localparam logic [KEYSYM_WIDTH-1:0] KS_F5        = 29'hFFC2;
   localparam logic [KEYSYM_WIDTH-1:0] KS_F6        = 29'hFFC3;
   localparam logic [KEYSYM_WIDTH-1:0] KS_F7        = 29'hFFC4;
   localparam logic [KEYSYM_WIDTH-1:0] KS_F8        = 29'hFFC5;
   localparam logic [KEYSYM_WIDTH-1:0] KS_F9        = 29'hFFC6;
   localparam logic [KEYSYM_WIDTH-1:0] KS_F10       = 29'hFFC7;
   localparam logic [KEYSYM_WIDTH-1:0] KS_F11       = 29'hFFC8;
   localparam logic [KEYSYM_WIDTH-1:0] KS_F12       = 29'hFFC9;
   localparam logic [KEYSYM_WIDTH-1:0] KS_DELETE    = 29'hFFFF;
   localparam logic [KEYSYM_WIDTH-1:0] KS_LOWER_A   = 29'h61;
   localparam logic [KEYSYM_WIDTH-1:0] KS_LOWER_Z   = 29'h7A;
   localparam logic [KEYSYM_WIDTH-1:0] KS_UPPER_A   = 29'h41;
   localparam logic [KEYSYM_WIDTH-1:0] KS_UPPER_Z   = 29'h5A;
   localparam logic [KEYSYM_WIDTH-1:0] KS_BRACKETL  = 29'h5B;
   localparam logic [KEYSYM_WIDTH-1:0] KS_BACKSLASH = 29'h5C;
   localparam logic [KEYSYM_WIDTH-1:0] KS_BRACKETR  = 29'h5D;
   localparam logic [KEYSYM_WIDTH-1:0] KS_CARET     = 29'h5E;
   localparam logic [KEYSYM_WIDTH-1:0] KS_UNDERSCORE = 29'h5F;
   localparam logic [KEYSYM_WIDTH-1:0] KS_SPACE     = 29'h20;

   // configuration seen by the front end
   typedef struct packed {
      logic cursor_ss3;
      logic keypad_ss3;
      logic keymap_ready;
   } cfg_type;

   // one encoded key sequence, first byte in data[0]
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] data;
      logic [LEN_WIDTH-1:0]      len;
   } seq_type;

endpackage

// ===== sv/tkse_front.sv =====
// tkse_front: accepts key events and encodes each into one byte sequence
// depends on tkse_pkg
module tkse_front (
   input  logic                               req_push,
   input  logic [tkse_pkg::KEYSYM_WIDTH-1:0]  req_keysym,
   input  logic                               req_pressed,
   input  logic                               req_ctrl_held,
   input  logic                               req_shift_held,
   input  logic                               req_alt_held,
   input  logic [tkse_pkg::TEXT_WIDTH-1:0]    req_text_bytes,
   input  logic [tkse_pkg::TLEN_WIDTH-1:0]    req_text_len,
   input  tkse_pkg::cfg_type                  cfg,
   input  logic                               q_full,
   output logic                               q_push,
   output tkse_pkg::seq_type                  q_seq
);
   import tkse_pkg::*;

   function automatic seq_type put3(logic [7:0] mid, logic [7:0] fin);
      seq_type s;
      s = '0;
      s.data[0] = CH_ESC;
      s.data[1] = mid;
      s.data[2] = fin;
      s.len = 3'd3;
      return s;
   endfunction

   function automatic seq_type put_csi1(logic [7:0] fin, logic [7:0] mdig);
      seq_type s;
      s = '0;
      s.data[0] = CH_ESC;
      s.data[1] = CH_LBRACKET;
      s.data[2] = CH_ONE;
      s.data[3] = CH_SEMI;
      s.data[4] = mdig;
      s.data[5] = fin;
      s.len = 3'd6;
      return s;
   endfunction

   function automatic seq_type put_tilde(logic [3:0] tens, logic [3:0] ones,
                                         logic has_mod, logic [7:0] mdig);
      seq_type s;
      logic [2:0] n;
      s = '0;
      s.data[0] = CH_ESC;
      s.data[1] = CH_LBRACKET;
      n = 3'd2;
      if (tens != 4'd0) begin
         s.data[n] = CH_ZERO + {4'd0, tens};
         n = n + 3'd1;
      end
      s.data[n] = CH_ZERO + {4'd0, ones};
      n = n + 3'd1;
      if (has_mod) begin
         s.data[n] = CH_SEMI;
         s.data[n + 3'd1] = mdig;
         n = n + 3'd2;
      end
      s.data[n] = CH_TILDE;
      s.len = n + 3'd1;
      return s;
   endfunction

   function automatic seq_type put_pref(logic alt, logic [7:0] c);
      seq_type s;
      s = '0;
      if (alt) begin
         s.data[0] = CH_ESC;
         s.data[1] = c;
         s.len = 3'd2;
      end else begin
         s.data[0] = c;
         s.len = 3'd1;
      end
      return s;
   endfunction

   logic [3:0]  mod_num;
   logic [7:0]  mod_dig;
   logic        has_mod;
   logic [7:0]  lead;
   logic [7:0]  kp_fin;
   seq_type     kp_seq;
   seq_type     spec_seq;
   logic        spec_hit;
   seq_type     ctrl_seq;
   logic        ctrl_hit;
   seq_type     text_seq;
   logic [2:0]  tlen;
   logic [7:0]  byte0;
   seq_type     enc_seq;

   // modifier number 1 + shift + 2*alt + 4*ctrl
   assign mod_num = {1'b0, req_ctrl_held, req_alt_held, req_shift_held} + 4'd1;
   assign mod_dig = CH_ZERO + {4'd0, mod_num};
   assign has_mod = req_ctrl_held | req_alt_held | req_shift_held;
   assign lead    = cfg.cursor_ss3 ? CH_O : CH_LBRACKET;

   // application keypad finals
   always_comb begin
      kp_fin = CH_NUL;
      if (req_keysym >= KS_KP_0 && req_keysym <= KS_KP_9) begin
         kp_fin = KP_FIN_DIGIT + {4'd0, req_keysym[3:0]};
      end else begin
         unique case (req_keysym)
            KS_KP_DEC:   kp_fin = KP_FIN_DEC;
            KS_KP_SEP:   kp_fin = KP_FIN_SEP;
            KS_KP_ADD:   kp_fin = KP_FIN_ADD;
            KS_KP_SUB:   kp_fin = KP_FIN_SUB;
            KS_KP_MULT:  kp_fin = KP_FIN_MULT;
            KS_KP_DIV:   kp_fin = KP_FIN_DIV;
            KS_KP_ENTER: kp_fin = KP_FIN_ENTER;
            default:     kp_fin = CH_NUL;
         endcase
      end
      kp_seq = put3(CH_O, kp_fin);
   end

   // named special keys
   always_comb begin
      spec_hit = 1'b1;
      spec_seq = '0;
      unique case (req_keysym)
         KS_RETURN, KS_KP_ENTER: spec_seq = put_pref(req_alt_held, CH_CR);
         KS_BACKSPACE:           spec_seq = put_pref(req_alt_held, CH_DEL);
         KS_TAB: begin
            if (req_shift_held) spec_seq = put3(CH_LBRACKET, FIN_Z);
            else                spec_seq = put_pref(req_alt_held, CH_TAB);
         end
         KS_ESCAPE: spec_seq = put_pref(1'b0, CH_ESC);
         KS_UP:    spec_seq = has_mod ? put_csi1(FIN_A, mod_dig) : put3(lead, FIN_A);
         KS_DOWN:  spec_seq = has_mod ? put_csi1(FIN_B, mod_dig) : put3(lead, FIN_B);
         KS_RIGHT: spec_seq = has_mod ? put_csi1(FIN_C, mod_dig) : put3(lead, FIN_C);
         KS_LEFT:  spec_seq = has_mod ? put_csi1(FIN_D, mod_dig) : put3(lead, FIN_D);
         KS_HOME:  spec_seq = has_mod ? put_csi1(FIN_H, mod_dig) : put3(lead, FIN_H);
         KS_END:   spec_seq = has_mod ? put_csi1(FIN_F, mod_dig) : put3(lead, FIN_F);
         KS_PRIOR:  spec_seq = put_tilde(4'd0, 4'd5, has_mod, mod_dig);
         KS_NEXT:   spec_seq = put_tilde(4'd0, 4'd6, has_mod, mod_dig);
         KS_INSERT: spec_seq = put_tilde(4'd0, 4'd2, has_mod, mod_dig);
         KS_DELETE: spec_seq = put_tilde(4'd0, 4'd3, has_mod, mod_dig);
         KS_F1: spec_seq = has_mod ? put_csi1(FIN_P, mod_dig) : put3(CH_O, FIN_P);
         KS_F2: spec_seq = has_mod ? put_csi1(FIN_Q, mod_dig) : put3(CH_O, FIN_Q);
         KS_F3: spec_seq = has_mod ? put_csi1(FIN_R, mod_dig) : put3(CH_O, FIN_R);
         KS_F4: spec_seq = has_mod ? put_csi1(FIN_S, mod_dig) : put3(CH_O, FIN_S);
         KS_F5:  spec_seq = put_tilde(4'd1, 4'd5, has_mod, mod_dig);
         KS_F6:  spec_seq = put_tilde(4'd1, 4'd7, has_mod, mod_dig);
         KS_F7:  spec_seq = put_tilde(4'd1, 4'd8, has_mod, mod_dig);
         KS_F8:  spec_seq = put_tilde(4'd1, 4'd9, has_mod, mod_dig);
         KS_F9:  spec_seq = put_tilde(4'd2, 4'd0, has_mod, mod_dig);
         KS_F10: spec_seq = put_tilde(4'd2, 4'd1, has_mod, mod_dig);
         KS_F11: spec_seq = put_tilde(4'd2, 4'd3, has_mod, mod_dig);
         KS_F12: spec_seq = put_tilde(4'd2, 4'd4, has_mod, mod_dig);
         default: spec_hit = 1'b0;
      endcase
   end

   // control codes
   always_comb begin
      ctrl_hit = 1'b1;
      ctrl_seq = '0;
      if (req_keysym >= KS_LOWER_A && req_keysym <= KS_LOWER_Z) begin
         ctrl_seq = put_pref(req_alt_held, req_keysym[7:0] - 8'h60);
      end else if (req_keysym >= KS_UPPER_A && req_keysym <= KS_UPPER_Z) begin
         ctrl_seq = put_pref(req_alt_held, req_keysym[7:0] - 8'h40);
      end else begin
         unique case (req_keysym)
            KS_BRACKETL:   ctrl_seq = put_pref(1'b0, CH_ESC);
            KS_BACKSLASH:  ctrl_seq = put_pref(1'b0, CH_FS);
            KS_BRACKETR:   ctrl_seq = put_pref(1'b0, CH_GS);
            KS_CARET:      ctrl_seq = put_pref(1'b0, CH_RS);
            KS_UNDERSCORE: ctrl_seq = put_pref(1'b0, CH_US);
            KS_SPACE:      ctrl_seq = put_pref(1'b0, CH_NUL);
            default:       ctrl_hit = 1'b0;
         endcase
      end
   end

   // plain text, length saturated to four
   assign tlen  = (req_text_len > 3'd4) ? 3'd4 : req_text_len;
   assign byte0 = req_text_bytes[7:0];

   always_comb begin
      text_seq = '0;
      if (tlen == 3'd0 || byte0 < CH_PRINT_MIN) begin
         text_seq.len = 3'd0;
      end else if (req_alt_held && tlen == 3'd1 && byte0 < CH_NON_ASCII) begin
         text_seq = put_pref(1'b1, byte0);
      end else begin
         text_seq.data[3:0] = req_text_bytes;
         text_seq.len = tlen;
      end
   end

   always_comb begin
      priority if (!cfg.keymap_ready || !req_pressed) begin
         enc_seq = '0;
      end else if (cfg.keypad_ss3 && kp_fin != CH_NUL) begin
         enc_seq = kp_seq;
      end else if (spec_hit) begin
         enc_seq = spec_seq;
      end else if (req_ctrl_held && ctrl_hit) begin
         enc_seq = ctrl_seq;
      end else begin
         enc_seq = text_seq;
      end
   end

   // events that encode to nothing are dropped here
   assign q_push = req_push && !q_full && enc_seq.len != 3'd0;
   assign q_seq  = enc_seq;

endmodule

// ===== sv/tkse_queue.sv =====
// tkse_queue: short queue of encoded sequences between front and back end
// depends on tkse_pkg
module tkse_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tkse_pkg::seq_type push_seq,
   output logic              full,
   input  logic              pop,
   output logic              avail,
   output tkse_pkg::seq_type head_seq
);
   import tkse_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   seq_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign avail    = count_ff != '0;
   assign head_seq = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_seq;
      end
   end

endmodule

// ===== sv/tkse_back.sv =====
// tkse_back: serializes queued sequences into the result register, one byte per
// cycle while that register is empty or popped; depends on tkse_pkg
module tkse_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_avail,
   input  tkse_pkg::seq_type q_seq,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_byte
);
   import tkse_pkg::*;

   logic                          cur_valid_ff, cur_valid_in;
   logic [MAX_BYTES-1:0][7:0]     cur_data_ff, cur_data_in;
   logic [LEN_WIDTH-1:0]          cur_remain_ff, cur_remain_in;
   logic                          out_valid_ff, out_valid_in;
   logic [7:0]                    out_byte_ff, out_byte_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_free, emit, cur_done;

   assign out_free = !out_valid_ff || rsp_pop;
   assign emit     = cur_valid_ff && out_free;
   assign cur_done = emit && cur_remain_ff == LEN_WIDTH'(1);
   assign q_pop    = q_avail && (!cur_valid_ff || cur_done);

   always_comb begin
      cur_valid_in  = cur_valid_ff;
      cur_data_in   = cur_data_ff;
      cur_remain_in = cur_remain_ff;
      if (q_pop) begin
         cur_valid_in  = 1'b1;
         cur_data_in   = q_seq.data;
         cur_remain_in = q_seq.len;
      end else if (emit) begin
         cur_valid_in  = !cur_done;
         cur_data_in   = cur_data_ff >> 8;
         cur_remain_in = cur_remain_ff - 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_data_ff[0];
         out_last_in  = cur_remain_ff == LEN_WIDTH'(1);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_data_ff   <= cur_data_in;
      cur_remain_ff <= cur_remain_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_last_byte = out_last_ff;

endmodule

// ===== sv/terminal_key_sequence_encoder.sv =====
// terminal_key_sequence_encoder: top level, key events in, terminal bytes out
// depends on tkse_pkg, tkse_front, tkse_queue, tkse_back
//
//   channel   handshake              payload
//   req       push / full            keysym, pressed, modifiers, text_bytes, text_len
//   rsp       empty / pop            out_byte, last_byte
//   csr       valid / ready          index, wdata
//
// the front end encodes an event in the cycle it is accepted and writes the
// whole sequence (one to seven bytes) into the queue; events that give no bytes
// are accepted and dropped. a new event is taken every cycle while the queue
// has room. the back end drains one byte per cycle while rsp is popped; the
// first byte passes the queue, the serializer and the result register before
// it shows. reset clears queue, serializer, result and config registers.
// a stalled rsp holds its byte; the queue then fills and raises full.
module terminal_key_sequence_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // event channel
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [tkse_pkg::KEYSYM_WIDTH-1:0]     req_keysym,
   input  logic                                  req_pressed,
   input  logic                                  req_ctrl_held,
   input  logic                                  req_shift_held,
   input  logic                                  req_alt_held,
   input  logic [tkse_pkg::TEXT_WIDTH-1:0]       req_text_bytes,
   input  logic [tkse_pkg::TLEN_WIDTH-1:0]       req_text_len,
   // byte channel
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_last_byte,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tkse_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic                                  csr_wdata
);
   import tkse_pkg::*;

   logic     cursor_ss3_ff, cursor_ss3_in;
   logic     keypad_ss3_ff, keypad_ss3_in;
   logic     keymap_ready_ff, keymap_ready_in;
   cfg_type  cfg;
   logic     q_push, q_full, q_pop, q_avail;
   seq_type  push_seq, head_seq;

   // config registers, always ready; unknown indexes are ignored
   assign csr_ready = 1'b1;

   always_comb begin
      cursor_ss3_in   = cursor_ss3_ff;
      keypad_ss3_in   = keypad_ss3_ff;
      keymap_ready_in = keymap_ready_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CURSOR_SS3:   cursor_ss3_in   = csr_wdata;
            CSR_KEYPAD_SS3:   keypad_ss3_in   = csr_wdata;
            CSR_KEYMAP_READY: keymap_ready_in = csr_wdata;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ss3_ff   <= 1'b0;
         keypad_ss3_ff   <= 1'b0;
         keymap_ready_ff <= 1'b0;
      end else begin
         cursor_ss3_ff   <= cursor_ss3_in;
         keypad_ss3_ff   <= keypad_ss3_in;
         keymap_ready_ff <= keymap_ready_in;
      end
   end

   assign cfg.cursor_ss3   = cursor_ss3_ff;
   assign cfg.keypad_ss3   = keypad_ss3_ff;
   assign cfg.keymap_ready = keymap_ready_ff;

   // event acceptance follows queue space only
   assign req_full = q_full;

   tkse_front u_front (
      .req_push       (req_push),
      .req_keysym     (req_keysym),
      .req_pressed    (req_pressed),
      .req_ctrl_held  (req_ctrl_held),
      .req_shift_held (req_shift_held),
      .req_alt_held   (req_alt_held),
      .req_text_bytes (req_text_bytes),
      .req_text_len   (req_text_len),
      .cfg            (cfg),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_seq          (push_seq)
   );

   tkse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_seq (push_seq),
      .full     (q_full),
      .pop      (q_pop),
      .avail    (q_avail),
      .head_seq (head_seq)
   );

   tkse_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_avail       (q_avail),
      .q_seq         (head_seq),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

// ===== sv/tkse_checker.sv =====
// tkse_checker: port-level assertions for the terminal key sequence encoder
// depends on nothing; bound to terminal_key_sequence_encoder below
module tkse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_byte
);

   // nothing waits on either side right after a reset cycle
   property p_reset_clears;
      @(posedge clock) reset |=> (rsp_empty && !req_full);
   endproperty
   a_reset_clears: assert property (p_reset_clears)
      else $error("queue or result not cleared by reset");

   // a sequence never breaks up: after a middle byte the next one is ready
   property p_no_gap;
      @(posedge clock) disable iff (reset)
         (!rsp_empty && rsp_pop && !rsp_last_byte) |=> !rsp_empty;
   endproperty
   a_no_gap: assert property (p_no_gap)
      else $error("gap inside a key sequence");

   // a stalled byte holds
   property p_hold;
      @(posedge clock) disable iff (reset)
         (!rsp_empty && !rsp_pop) |=>
            (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_last_byte));
   endproperty
   a_hold: assert property (p_hold)
      else $error("result changed while stalled");

   // with the result side empty and staying empty, queue cannot be full
   property p_full_needs_backlog;
      @(posedge clock) disable iff (reset)
         ($past(rsp_empty) && rsp_empty && !$past(reset)) |-> !req_full;
   endproperty
   a_full_needs_backlog: assert property (p_full_needs_backlog)
      else $error("full while nothing is being delivered");

endmodule

bind terminal_key_sequence_encoder tkse_checker u_tkse_checker (
   .clock         (clock),
   .reset         (reset),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last_byte (rsp_last_byte)
);

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench of the terminal key sequence encoder
// depends on tkse_pkg and terminal_key_sequence_encoder; key events are
// queued, driven with random gaps and checked byte by byte at the output
`timescale 1ns / 100ps

module tb_top;
   import tkse_pkg::*;

   // one key event as it travels on the req channel
   typedef struct {
      logic [KEYSYM_WIDTH-1:0] keysym;
      logic                    pressed;
      logic                    ctrl;
      logic                    shift;
      logic                    alt;
      logic [TEXT_WIDTH-1:0]   text;
      logic [TLEN_WIDTH-1:0]   tlen;
   } key_event_type;

   // one expected byte of the output stream
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } seq_byte_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   logic [KEYSYM_WIDTH-1:0]  req_keysym = '0;
   logic                     req_pressed = 1'b0;
   logic                     req_ctrl_held = 1'b0;
   logic                     req_shift_held = 1'b0;
   logic                     req_alt_held = 1'b0;
   logic [TEXT_WIDTH-1:0]    req_text_bytes = '0;
   logic [TLEN_WIDTH-1:0]    req_text_len = '0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   logic [7:0]               rsp_out_byte;
   logic                     rsp_last_byte;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic                     csr_wdata = 1'b0;

   // shadow copy of the configuration registers
   logic cfg_cursor = 1'b0;
   logic cfg_keypad = 1'b0;
   logic cfg_ready  = 1'b0;

   key_event_type pending_events[$];   // events still to be sent
   seq_byte_type  expected_bytes[$];   // bytes the encoder still owes us
   logic [7:0]    key_seq[$];          // scratch: sequence of the current event
   int            mismatches = 0;

   // handshake flags set at the rising edge, consumed by the drivers
   bit req_took = 1'b0;
   bit rsp_took = 1'b0;
   int req_gap = 0;
   int req_burst = 0;
   int rsp_stall = 0;
   int rsp_burst = 0;

   always #5 clock = ~clock;

   terminal_key_sequence_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_keysym     (req_keysym),
      .req_pressed    (req_pressed),
      .req_ctrl_held  (req_ctrl_held),
      .req_shift_held (req_shift_held),
      .req_alt_held   (req_alt_held),
      .req_text_bytes (req_text_bytes),
      .req_text_len   (req_text_len),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // ------------------------------------------------------------------
   // sequence builders, all append to key_seq
   // ------------------------------------------------------------------

   function automatic void push_three(input logic [7:0] mid, input logic [7:0] fin);
      key_seq.push_back(CH_ESC);
      key_seq.push_back(mid);
      key_seq.push_back(fin);
   endfunction

   // optional ESC in front of a single byte
   function automatic void push_prefixed(input logic alt, input logic [7:0] c);
      if (alt) key_seq.push_back(CH_ESC);
      key_seq.push_back(c);
   endfunction

   // cursor style keys: ESC [ 1 ; m X with modifiers, else ESC lead X
   function automatic void push_cursor(input logic [7:0] fin, input logic [3:0] m,
                                       input logic [7:0] lead);
      if (m > 4'd1) begin
         key_seq.push_back(CH_ESC);
         key_seq.push_back(CH_LBRACKET);
         key_seq.push_back(CH_ONE);
         key_seq.push_back(CH_SEMI);
         key_seq.push_back(CH_ZERO + {4'd0, m});
         key_seq.push_back(fin);
      end else begin
         push_three(lead, fin);
      end
   endfunction

   // tilde keys: ESC [ n ~ or ESC [ n ; m ~, n of one or two digits
   function automatic void push_tilde(input int code, input logic [3:0] m);
      key_seq.push_back(CH_ESC);
      key_seq.push_back(CH_LBRACKET);
      if (code >= 10) key_seq.push_back(CH_ZERO + 8'(code / 10));
      key_seq.push_back(CH_ZERO + 8'(code % 10));
      if (m != 4'd1) begin
         key_seq.push_back(CH_SEMI);
         key_seq.push_back(CH_ZERO + {4'd0, m});
      end
      key_seq.push_back(CH_TILDE);
   endfunction

   // final byte of the application keypad form, zero when not a keypad key
   function automatic logic [7:0] keypad_final(input logic [KEYSYM_WIDTH-1:0] ks);
      if (ks >= KS_KP_0 && ks <= KS_KP_9) return KP_FIN_DIGIT + 8'(ks - KS_KP_0);
      case (ks)
         KS_KP_DEC:   return KP_FIN_DEC;
         KS_KP_SEP:   return KP_FIN_SEP;
         KS_KP_ADD:   return KP_FIN_ADD;
         KS_KP_SUB:   return KP_FIN_SUB;
         KS_KP_MULT:  return KP_FIN_MULT;
         KS_KP_DIV:   return KP_FIN_DIV;
         KS_KP_ENTER: return KP_FIN_ENTER;
         default:     return CH_NUL;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // predictor: encodes one accepted event and queues its bytes
   // ------------------------------------------------------------------
   function automatic void encode_key_event(input key_event_type ev);
      logic [3:0] m;
      logic [7:0] lead;
      logic [7:0] kp;
      logic [7:0] first;
      int         n_text;
      key_seq.delete();
      // modifier digit is 1 + shift + 2*alt + 4*ctrl
      m = 4'd1 + {3'd0, ev.shift} + {2'd0, ev.alt, 1'b0} + {1'b0, ev.ctrl, 2'b0};
      lead = cfg_cursor ? CH_O : CH_LBRACKET;
      kp = keypad_final(ev.keysym);
      first = ev.text[7:0];
      // text length saturates at four bytes
      n_text = (ev.tlen > 3'd4) ? 4 : int'(ev.tlen);
      if (cfg_ready && ev.pressed) begin
         if (cfg_keypad && kp != CH_NUL) begin
            push_three(CH_O, kp);
         end else begin
            case (ev.keysym)
               KS_RETURN, KS_KP_ENTER: push_prefixed(ev.alt, CH_CR);
               KS_BACKSPACE:           push_prefixed(ev.alt, CH_DEL);
               KS_TAB: begin
                  // back-tab ignores alt
                  if (ev.shift) push_three(CH_LBRACKET, FIN_Z);
                  else push_prefixed(ev.alt, CH_TAB);
               end
               KS_ESCAPE: key_seq.push_back(CH_ESC);
               KS_UP:     push_cursor(FIN_A, m, lead);
               KS_DOWN:   push_cursor(FIN_B, m, lead);
               KS_RIGHT:  push_cursor(FIN_C, m, lead);
               KS_LEFT:   push_cursor(FIN_D, m, lead);
               KS_HOME:   push_cursor(FIN_H, m, lead);
               KS_END:    push_cursor(FIN_F, m, lead);
               KS_PRIOR:  push_tilde(5, m);
               KS_NEXT:   push_tilde(6, m);
               KS_INSERT: push_tilde(2, m);
               KS_DELETE: push_tilde(3, m);
               // F1..F4 always use the O lead when unmodified
               KS_F1:     push_cursor(FIN_P, m, CH_O);
               KS_F2:     push_cursor(FIN_Q, m, CH_O);
               KS_F3:     push_cursor(FIN_R, m, CH_O);
               KS_F4:     push_cursor(FIN_S, m, CH_O);
               KS_F5:     push_tilde(15, m);
               KS_F6:     push_tilde(17, m);
               KS_F7:     push_tilde(18, m);
               KS_F8:     push_tilde(19, m);
               KS_F9:     push_tilde(20, m);
               KS_F10:    push_tilde(21, m);
               KS_F11:    push_tilde(23, m);
               KS_F12:    push_tilde(24, m);
               default: begin
                  if (ev.ctrl && ev.keysym >= KS_LOWER_A && ev.keysym <= KS_LOWER_Z)
                     push_prefixed(ev.alt, 8'(ev.keysym - KS_LOWER_A + 1));
                  else if (ev.ctrl && ev.keysym >= KS_UPPER_A && ev.keysym <= KS_UPPER_Z)
                     push_prefixed(ev.alt, 8'(ev.keysym - KS_UPPER_A + 1));
                  else if (ev.ctrl && ev.keysym == KS_BRACKETL)
                     key_seq.push_back(CH_ESC);
                  else if (ev.ctrl && ev.keysym == KS_BACKSLASH)
                     key_seq.push_back(CH_FS);
                  else if (ev.ctrl && ev.keysym == KS_BRACKETR)
                     key_seq.push_back(CH_GS);
                  else if (ev.ctrl && ev.keysym == KS_CARET)
                     key_seq.push_back(CH_RS);
                  else if (ev.ctrl && ev.keysym == KS_UNDERSCORE)
                     key_seq.push_back(CH_US);
                  else if (ev.ctrl && ev.keysym == KS_SPACE)
                     key_seq.push_back(CH_NUL);
                  else if (n_text != 0 && first >= CH_PRINT_MIN) begin
                     // alt prefix only on a single ascii byte
                     if (ev.alt && n_text == 1 && first < CH_NON_ASCII)
                        push_prefixed(1'b1, first);
                     else
                        for (int i = 0; i < n_text; i++)
                           key_seq.push_back(ev.text[8*i +: 8]);
                  end
               end
            endcase
         end
      end
      foreach (key_seq[i])
         expected_bytes.push_back({key_seq[i], i == key_seq.size() - 1});
   endfunction

   // ------------------------------------------------------------------
   // stimulus generation
   // ------------------------------------------------------------------

   function automatic key_event_type make_key(input logic [KEYSYM_WIDTH-1:0] ks,
                                              input logic c, input logic s, input logic a,
                                              input logic [TEXT_WIDTH-1:0] text,
                                              input logic [TLEN_WIDTH-1:0] tlen);
      key_event_type ev;
      ev.keysym = ks;
      ev.pressed = 1'b1;
      ev.ctrl = c;
      ev.shift = s;
      ev.alt = a;
      ev.text = text;
      ev.tlen = tlen;
      return ev;
   endfunction

   // every keysym with a fixed sequence, keypad digits folded into one slot
   function automatic logic [KEYSYM_WIDTH-1:0] special_key(input int idx);
      case (idx)
         0:  return KS_BACKSPACE;
         1:  return KS_TAB;
         2:  return KS_RETURN;
         3:  return KS_ESCAPE;
         4:  return KS_HOME;
         5:  return KS_LEFT;
         6:  return KS_UP;
         7:  return KS_RIGHT;
         8:  return KS_DOWN;
         9:  return KS_PRIOR;
         10: return KS_NEXT;
         11: return KS_END;
         12: return KS_INSERT;
         13: return KS_KP_ENTER;
         14: return KS_KP_MULT;
         15: return KS_KP_ADD;
         16: return KS_KP_SEP;
         17: return KS_KP_SUB;
         18: return KS_KP_DEC;
         19: return KS_KP_DIV;
         20: return KS_KP_0 + KEYSYM_WIDTH'($urandom_range(0, 9));
         21: return KS_F1;
         22: return KS_F2;
         23: return KS_F3;
         24: return KS_F4;
         25: return KS_F5;
         26: return KS_F6;
         27: return KS_F7;
         28: return KS_F8;
         29: return KS_F9;
         30: return KS_F10;
         31: return KS_F11;
         32: return KS_F12;
         default: return KS_DELETE;
      endcase
   endfunction

   // mostly well-formed keys with random modifiers, some raw noise
   function automatic key_event_type random_key_event();
      key_event_type ev;
      int            kind;
      kind = $urandom_range(0, 99);
      ev.keysym = KEYSYM_WIDTH'($urandom());
      ev.pressed = ($urandom_range(0, 7) != 0);
      ev.ctrl = ($urandom_range(0, 2) == 0);
      ev.shift = ($urandom_range(0, 2) == 0);
      ev.alt = ($urandom_range(0, 2) == 0);
      ev.text = $urandom();
      ev.tlen = $urandom_range(0, 1) ? 3'd1 : TLEN_WIDTH'($urandom_range(1, 4));
      if (kind < 40) begin
         ev.keysym = special_key($urandom_range(0, 33));
      end else if (kind < 55) begin
         ev.ctrl = 1'b1;
         case ($urandom_range(0, 3))
            0: ev.keysym = KS_LOWER_A + KEYSYM_WIDTH'($urandom_range(0, 25));
            1: ev.keysym = KS_UPPER_A + KEYSYM_WIDTH'($urandom_range(0, 25));
            2: ev.keysym = KS_BRACKETL + KEYSYM_WIDTH'($urandom_range(0, 4));
            default: ev.keysym = KS_SPACE;
         endcase
      end else if (kind < 88) begin
         // plain typing, now and then a control byte as text
         ev.keysym = KEYSYM_WIDTH'($urandom_range(32'h20, 32'h7E));
         if ($urandom_range(0, 5) == 0)
            ev.text[7:0] = 8'($urandom_range(0, 31));
         else if ($urandom_range(0, 1) == 1)
            ev.text[7:0] = 8'($urandom_range(32'h20, 32'h7E));
      end else begin
         ev.tlen = TLEN_WIDTH'($urandom_range(0, 7));
      end
      return ev;
   endfunction

   // per transaction wait: random gap, with runs of back-to-back traffic
   task automatic draw_wait(inout int burst, output int cycles);
      if (burst > 0) begin
         burst--;
         cycles = 0;
      end else if ($urandom_range(0, 7) == 0) begin
         burst = $urandom_range(4, 20);
         cycles = 0;
      end else begin
         cycles = $urandom_range(0, 16);
      end
   endtask

   // ------------------------------------------------------------------
   // event driver: changes req_ signals at the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin : event_driver
      key_event_type ev;
      if (reset) begin
         req_push <= 1'b0;
      end else if (!(req_push && !req_took)) begin
         // either idle or the last transaction just went through
         if (req_took) begin
            req_took = 1'b0;
            draw_wait(req_burst, req_gap);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_push <= 1'b0;
         end else if (pending_events.size() != 0) begin
            ev = pending_events.pop_front();
            req_keysym     <= ev.keysym;
            req_pressed    <= ev.pressed;
            req_ctrl_held  <= ev.ctrl;
            req_shift_held <= ev.shift;
            req_alt_held   <= ev.alt;
            req_text_bytes <= ev.text;
            req_text_len   <= ev.tlen;
            req_push       <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // byte sink: pop stays high unless a stall was drawn for this byte
   always @(negedge clock) begin : byte_sink
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_took) begin
            rsp_took = 1'b0;
            draw_wait(rsp_burst, rsp_stall);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: both channels sampled at the rising edge; the byte check
   // runs before the new event is predicted
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      key_event_type ev;
      seq_byte_type  exp_b;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            rsp_took = 1'b1;
            if (expected_bytes.size() == 0) begin
               $error("unexpected transaction: out_byte %h last_byte %b",
                      rsp_out_byte, rsp_last_byte);
               mismatches++;
            end else begin
               exp_b = expected_bytes.pop_front();
               if (rsp_out_byte !== exp_b.data) begin
                  $error("out_byte mismatch: expected %h, actual %h",
                         exp_b.data, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_last_byte !== exp_b.last) begin
                  $error("last_byte mismatch: expected %b, actual %b",
                         exp_b.last, rsp_last_byte);
                  mismatches++;
               end
            end
         end
         if (req_push && !req_full) begin
            req_took = 1'b1;
            ev.keysym  = req_keysym;
            ev.pressed = req_pressed;
            ev.ctrl    = req_ctrl_held;
            ev.shift   = req_shift_held;
            ev.alt     = req_alt_held;
            ev.text    = req_text_bytes;
            ev.tlen    = req_text_len;
            encode_key_event(ev);
         end
      end
   end

   // ------------------------------------------------------------------
   // configuration and phase control
   // ------------------------------------------------------------------

   // one register write; valid is left high for a following write
   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx, input logic val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CURSOR_SS3:   cfg_cursor = val;
         CSR_KEYPAD_SS3:   cfg_keypad = val;
         CSR_KEYMAP_READY: cfg_ready  = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic cursor, input logic keypad, input logic ready);
      write_csr(CSR_CURSOR_SS3, cursor);
      write_csr(CSR_KEYPAD_SS3, keypad);
      write_csr(CSR_KEYMAP_READY, ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every event is sent and every byte is back, then let a
   // dropped event still in flight clear the pipeline
   task automatic drain();
      while (pending_events.size() != 0 || req_push || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin : stimulus
      key_event_type ev;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // keymap not loaded: everything is swallowed
      set_config(1'b0, 1'b0, 1'b0);
      repeat (12) pending_events.push_back(random_key_event());
      drain();

      // normal modes, directed keys first
      set_config(1'b0, 1'b0, 1'b1);
      pending_events.push_back(make_key(KS_KP_ENTER, 1'b0, 1'b0, 1'b1, '0, 3'd0));
      pending_events.push_back(make_key(KS_BACKSPACE, 1'b0, 1'b0, 1'b1, '0, 3'd0));
      // back-tab with alt still gives ESC [ Z
      pending_events.push_back(make_key(KS_TAB, 1'b0, 1'b1, 1'b1, '0, 3'd0));
      pending_events.push_back(make_key(KS_ESCAPE, 1'b0, 1'b0, 1'b0, '0, 3'd0));
      pending_events.push_back(make_key(KS_UP, 1'b0, 1'b0, 1'b0, '0, 3'd0));
      pending_events.push_back(make_key(KS_UP, 1'b1, 1'b1, 1'b1, '0, 3'd0));
      pending_events.push_back(make_key(KS_F1, 1'b0, 1'b0, 1'b0, '0, 3'd0));
      // alt on function keys adds no ESC prefix
      pending_events.push_back(make_key(KS_F4, 1'b0, 1'b0, 1'b1, '0, 3'd0));
      pending_events.push_back(make_key(KS_PRIOR, 1'b0, 1'b0, 1'b0, '0, 3'd0));
      pending_events.push_back(make_key(KS_DELETE, 1'b1, 1'b0, 1'b0, '0, 3'd0));
      // longest sequence: two digit code with modifier
      pending_events.push_back(make_key(KS_F5, 1'b1, 1'b1, 1'b1, '0, 3'd0));
      pending_events.push_back(make_key(KS_LOWER_A, 1'b1, 1'b0, 1'b1, '0, 3'd0));
      pending_events.push_back(make_key(KS_BRACKETL, 1'b1, 1'b0, 1'b0, '0, 3'd0));
      pending_events.push_back(make_key(KS_BACKSLASH, 1'b1, 1'b0, 1'b0, '0, 3'd0));
      pending_events.push_back(make_key(KS_BRACKETR, 1'b1, 1'b0, 1'b0, '0, 3'd0));
      pending_events.push_back(make_key(KS_CARET, 1'b1, 1'b0, 1'b0, '0, 3'd0));
      pending_events.push_back(make_key(KS_UNDERSCORE, 1'b1, 1'b0, 1'b0, '0, 3'd0));
      pending_events.push_back(make_key(KS_SPACE, 1'b1, 1'b0, 1'b0, '0, 3'd0));
      // alt with ascii byte, with a non-ascii byte, and with multibyte text
      pending_events.push_back(make_key(29'h61, 1'b0, 1'b0, 1'b1, 32'h61, 3'd1));
      pending_events.push_back(make_key(29'hE9, 1'b0, 1'b0, 1'b1, 32'hE9, 3'd1));
      pending_events.push_back(make_key(29'hE9, 1'b0, 1'b0, 1'b1, 32'hA9C3, 3'd2));
      // oversized length saturates to four bytes
      pending_events.push_back(make_key(29'h41, 1'b0, 1'b0, 1'b0, 32'h44434241, 3'd7));
      // control byte as text and unmapped key without text: nothing
      pending_events.push_back(make_key(29'h1F, 1'b0, 1'b0, 1'b0, 32'h1F, 3'd1));
      pending_events.push_back(make_key('1, 1'b0, 1'b0, 1'b0, '1, 3'd0));
      // all-ones fields pass through as four bytes
      pending_events.push_back(make_key('1, 1'b0, 1'b1, 1'b1, '1, 3'd4));
      // release yields nothing
      ev = make_key(KS_UP, 1'b0, 1'b0, 1'b0, '0, 3'd0);
      ev.pressed = 1'b0;
      pending_events.push_back(ev);
      repeat (20) pending_events.push_back(random_key_event());
      drain();

      // both application modes on
      set_config(1'b1, 1'b1, 1'b1);
      repeat (25) pending_events.push_back(random_key_event());
      drain();

      set_config(1'b1, 1'b0, 1'b1);
      repeat (20) pending_events.push_back(random_key_event());
      drain();

      set_config(1'b0, 1'b1, 1'b1);
      repeat (20) pending_events.push_back(random_key_event());
      drain();

      // keymap dropped again with modes still on
      set_config(1'b1, 1'b1, 1'b0);
      repeat (8) pending_events.push_back(random_key_event());
      drain();

      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== terminal_key_sequence_encoder.f =====
sv/tkse_pkg.sv
sv/tkse_front.sv
sv/tkse_queue.sv
sv/tkse_back.sv
sv/terminal_key_sequence_encoder.sv
sv/tkse_checker.sv
test/tb_top.sv
